### src/payment_part_aggregation_table_assert.svh
// assertion macros shared by the payment part aggregation table modules
`ifndef PAYMENT_PART_AGGREGATION_TABLE_ASSERT_SVH
`define PAYMENT_PART_AGGREGATION_TABLE_ASSERT_SVH

// property checked on every clock edge outside reset
`define PPAT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// property checked on every clock edge, reset included
`define PPAT_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

### src/ppat_pkg.sv
// shared types and constants of the payment part aggregation table
package ppat_pkg;

   localparam int KEY_W      = 256;
   localparam int WORD_W     = 64;
   localparam int TIME_W     = 32;
   localparam int COUNT_W    = 6;
   localparam int LIVE_OUT_W = 4;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd60;
   localparam logic              REG_TIMEOUT   = 1'b0;

   typedef enum logic [1:0] {
      KIND_ADD    = 2'd0,
      KIND_SWEEP  = 2'd1,
      KIND_LIST   = 2'd2,
      KIND_REMOVE = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STAT_REJECT     = 2'd0,
      STAT_INCOMPLETE = 2'd1,
      STAT_COMPLETE   = 2'd2,
      STAT_NOT_ADD    = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_DISPATCH,
      ST_ADD_SUM,
      ST_ADD_EVAL,
      ST_REC_RD,
      ST_REC_CHK,
      ST_ID_CHK,
      ST_ID_RD,
      ST_ID_OUT,
      ST_CLOSE
   } state_type;

   typedef struct packed {
      logic start;
      logic scan_chk;
      logic alloc;
      logic add_sum;
      logic add_eval;
      logic remove;
      logic sweep_commit;
      logic hold_rec;
      logic emit_id;
      logic emit_close;
   } ctrl_cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     match_found;
      logic     free_found;
      logic     expired;
      logic     more_ids;
      logic     out_free;
   } dp_sts_type;

endpackage

### src/ppat_ram.sv
// generic single write port ram with registered read
module ppat_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/ppat_ctrl.sv
// sequencer of the payment part aggregation table
`include "payment_part_aggregation_table_assert.svh"
module ppat_ctrl #(
   parameter int ENTRIES = 8,
   parameter int PARTS_PER_ENTRY = 8,
   localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
   localparam int HW = $clog2(PARTS_PER_ENTRY + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  ppat_pkg::dp_sts_type   sts,
   output ppat_pkg::ctrl_cmd_type cmd,
   output logic [EW-1:0]          idx,
   output logic [HW-1:0]          part_idx
);
   import ppat_pkg::*;

   state_type       state_ff, state_in;
   logic [EW-1:0]   idx_ff, idx_in;
   logic [HW-1:0]   j_ff, j_in;
   logic            last_entry;

   assign last_entry = (idx_ff == EW'(ENTRIES - 1));
   assign idx        = idx_ff;
   assign part_idx   = j_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:     if (req_valid) state_in = ST_SCAN_RD;
         ST_SCAN_RD:  state_in = ST_SCAN_CHK;
         ST_SCAN_CHK: state_in = last_entry ? ST_DISPATCH : ST_SCAN_RD;
         ST_DISPATCH: begin
            case (sts.kind)
               KIND_ADD:   state_in = (sts.match_found || sts.free_found) ?
                                      ST_ADD_SUM : ST_CLOSE;
               KIND_SWEEP: state_in = ST_REC_RD;
               KIND_LIST:  state_in = sts.match_found ? ST_ID_CHK : ST_CLOSE;
               default:    state_in = ST_CLOSE;
            endcase
         end
         ST_ADD_SUM:  state_in = ST_ADD_EVAL;
         ST_ADD_EVAL: state_in = ST_CLOSE;
         ST_REC_RD:   state_in = ST_REC_CHK;
         ST_REC_CHK: begin
            if (sts.expired) state_in = ST_ID_CHK;
            else state_in = last_entry ? ST_CLOSE : ST_REC_RD;
         end
         ST_ID_CHK: begin
            if (sts.more_ids) state_in = ST_ID_RD;
            else if (sts.kind == KIND_LIST || last_entry) state_in = ST_CLOSE;
            else state_in = ST_REC_RD;
         end
         ST_ID_RD:    state_in = ST_ID_OUT;
         ST_ID_OUT:   if (sts.out_free) state_in = ST_ID_CHK;
         ST_CLOSE:    if (sts.out_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // entry and part counters
   always_comb begin
      idx_in = idx_ff;
      j_in   = j_ff;
      case (state_ff)
         ST_IDLE:     if (req_valid) idx_in = '0;
         ST_SCAN_CHK: if (!last_entry) idx_in = idx_ff + EW'(1);
         ST_DISPATCH: begin
            idx_in = '0;
            j_in   = '0;
         end
         ST_REC_CHK: begin
            if (sts.expired) j_in = '0;
            else if (!last_entry) idx_in = idx_ff + EW'(1);
         end
         ST_ID_CHK: begin
            if (!sts.more_ids && sts.kind != KIND_LIST && !last_entry) begin
               idx_in = idx_ff + EW'(1);
            end
         end
         ST_ID_OUT:   if (sts.out_free) j_in = j_ff + HW'(1);
         default:     ;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.start = req_valid;
         end
         ST_SCAN_CHK: cmd.scan_chk = 1'b1;
         ST_DISPATCH: begin
            cmd.alloc        = (sts.kind == KIND_ADD) && !sts.match_found && sts.free_found;
            cmd.remove       = (sts.kind == KIND_REMOVE) && sts.match_found;
            cmd.sweep_commit = (sts.kind == KIND_SWEEP);
         end
         ST_ADD_SUM:  cmd.add_sum = 1'b1;
         ST_ADD_EVAL: cmd.add_eval = 1'b1;
         ST_REC_CHK:  cmd.hold_rec = 1'b1;
         ST_ID_OUT:   cmd.emit_id = sts.out_free;
         ST_CLOSE:    cmd.emit_close = sts.out_free;
         default:     ;
      endcase
   end

   // state and counter registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         j_ff     <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         j_ff     <= j_in;
      end
   end

   `PPAT_ASSERT_RST(a_reset_to_idle, reset |=> (state_ff == ST_IDLE), "fsm not idle after reset")
   `PPAT_ASSERT(a_scan_from_zero, cmd.start |=> (idx_ff == '0 && state_ff == ST_SCAN_RD), "scan did not start at entry zero")
   `PPAT_ASSERT(a_close_ends_item, cmd.emit_close |=> (state_ff == ST_IDLE), "closing transfer did not end the item")

endmodule

### src/ppat_dp.sv
// table storage, key match, part bookkeeping and result register
`include "payment_part_aggregation_table_assert.svh"
module ppat_dp #(
   parameter int ENTRIES = 8,
   parameter int PARTS_PER_ENTRY = 8,
   localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
   localparam int HW = $clog2(PARTS_PER_ENTRY + 1)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  ppat_pkg::ctrl_cmd_type           cmd,
   output ppat_pkg::dp_sts_type             sts,
   input  logic [EW-1:0]                    idx,
   input  logic [HW-1:0]                    part_idx,
   input  logic [ppat_pkg::TIME_W-1:0]      timeout_secs,
   input  logic [1:0]                       req_kind,
   input  logic [ppat_pkg::WORD_W-1:0]      req_secret_word_0,
   input  logic [ppat_pkg::WORD_W-1:0]      req_secret_word_1,
   input  logic [ppat_pkg::WORD_W-1:0]      req_secret_word_2,
   input  logic [ppat_pkg::WORD_W-1:0]      req_secret_word_3,
   input  logic [ppat_pkg::WORD_W-1:0]      req_part_id,
   input  logic [ppat_pkg::WORD_W-1:0]      req_part_amount,
   input  logic [ppat_pkg::WORD_W-1:0]      req_payment_total,
   input  logic [ppat_pkg::TIME_W-1:0]      req_now_seconds,
   input  logic [ppat_pkg::COUNT_W-1:0]     req_max_ids,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [1:0]                       rsp_status,
   output logic [ppat_pkg::WORD_W-1:0]      rsp_out_part_id,
   output logic                             rsp_id_valid,
   output logic [ppat_pkg::COUNT_W-1:0]     rsp_id_count,
   output logic [ppat_pkg::LIVE_OUT_W-1:0]  rsp_active_entries,
   output logic                             rsp_last
);
   import ppat_pkg::*;

   localparam int LW       = $clog2(ENTRIES + 1);
   localparam int PDEPTH   = ENTRIES * PARTS_PER_ENTRY;
   localparam int PW       = (PDEPTH > 1) ? $clog2(PDEPTH) : 1;
   localparam int HELD_LO  = 0;
   localparam int FIRST_LO = HW;
   localparam int SUM_LO   = FIRST_LO + TIME_W;
   localparam int TOTAL_LO = SUM_LO + WORD_W;
   localparam int KEY_LO   = TOTAL_LO + WORD_W;
   localparam int REC_W    = KEY_LO + KEY_W;

   // item registers
   kind_type              kind_ff, kind_in;
   logic [KEY_W-1:0]      key_ff, key_in;
   logic [WORD_W-1:0]     id_ff, id_in;
   logic [WORD_W-1:0]     amount_ff, amount_in;
   logic [WORD_W-1:0]     total_ff, total_in;
   logic [TIME_W-1:0]     now_ff, now_in;
   logic [COUNT_W-1:0]    max_ff, max_in;

   // table state and scan results
   logic [ENTRIES-1:0]    active_ff, active_in;
   logic [LW-1:0]         live_ff, live_in;
   logic                  match_ff, match_in;
   logic                  free_ff, free_in;
   logic [EW-1:0]         match_idx_ff, match_idx_in;
   logic [EW-1:0]         free_idx_ff, free_idx_in;
   logic [ENTRIES-1:0]    expire_ff, expire_in;
   logic [LW-1:0]         exp_cnt_ff, exp_cnt_in;
   logic [REC_W-1:0]      hold_ff, hold_in;
   logic [WORD_W:0]       sum_ff, sum_in;
   logic [COUNT_W-1:0]    n_ff, n_in;
   status_type            status_ff, status_in;

   // result register
   logic                  out_valid_ff, out_valid_in;
   status_type            out_status_ff, out_status_in;
   logic [WORD_W-1:0]     out_id_ff, out_id_in;
   logic                  out_idv_ff, out_idv_in;
   logic [COUNT_W-1:0]    out_count_ff, out_count_in;
   logic [LIVE_OUT_W-1:0] out_live_ff, out_live_in;
   logic                  out_last_ff, out_last_in;

   // memories and helpers
   logic                  rec_wr_en;
   logic [REC_W-1:0]      rec_wr_data;
   logic [REC_W-1:0]      rec_rd;
   logic                  part_wr_en;
   logic [PW-1:0]         part_wr_addr;
   logic [PW-1:0]         part_rd_addr;
   logic [WORD_W-1:0]     part_rd;
   logic [EW-1:0]         sel_idx;
   logic [EW-1:0]         list_ent;
   logic [HW-1:0]         held;
   logic [WORD_W-1:0]     hold_total;
   logic [TIME_W-1:0]     expiry_time;
   logic                  key_hit;
   logic                  list_full;
   logic                  over_pay;
   logic                  part_ok;
   logic [WORD_W-1:0]     new_sum;
   logic                  out_free;

   assign sel_idx     = match_ff ? match_idx_ff : free_idx_ff;
   assign list_ent    = (kind_ff == KIND_SWEEP) ? idx : match_idx_ff;
   assign held        = hold_ff[HELD_LO +: HW];
   assign hold_total  = hold_ff[TOTAL_LO +: WORD_W];
   assign expiry_time = rec_rd[FIRST_LO +: TIME_W] + timeout_secs;
   assign key_hit     = active_ff[idx] && (rec_rd[KEY_LO +: KEY_W] == key_ff);
   assign out_free    = !out_valid_ff || !rsp_stall;

   // add checks: part list limit and overpayment guard at 65 bits
   assign list_full = (held >= HW'(PARTS_PER_ENTRY));
   assign over_pay  = (sum_ff > {hold_total, 1'b0});
   assign part_ok   = !list_full && !over_pay;
   assign new_sum   = sum_ff[WORD_W] ? {WORD_W{1'b1}} : sum_ff[WORD_W-1:0];

   // part memory addressing, entry times parts per entry plus slot
   assign part_wr_addr = PW'(sel_idx) * PW'(PARTS_PER_ENTRY) + PW'(held);
   assign part_rd_addr = PW'(list_ent) * PW'(PARTS_PER_ENTRY) + PW'(part_idx);

   // status toward the sequencer
   always_comb begin
      sts.kind        = kind_ff;
      sts.match_found = match_ff;
      sts.free_found  = free_ff;
      sts.expired     = expire_ff[idx];
      sts.more_ids    = (part_idx < held) && (n_ff < max_ff);
      sts.out_free    = out_free;
   end

   // next values of table and item state
   always_comb begin
      kind_in      = kind_ff;
      key_in       = key_ff;
      id_in        = id_ff;
      amount_in    = amount_ff;
      total_in     = total_ff;
      now_in       = now_ff;
      max_in       = max_ff;
      active_in    = active_ff;
      live_in      = live_ff;
      match_in     = match_ff;
      free_in      = free_ff;
      match_idx_in = match_idx_ff;
      free_idx_in  = free_idx_ff;
      expire_in    = expire_ff;
      exp_cnt_in   = exp_cnt_ff;
      hold_in      = hold_ff;
      sum_in       = sum_ff;
      n_in         = n_ff;
      status_in    = status_ff;
      rec_wr_en    = 1'b0;
      rec_wr_data  = hold_ff;
      part_wr_en   = 1'b0;

      // capture the item and clear scan results
      if (cmd.start) begin
         kind_in    = kind_type'(req_kind);
         key_in     = {req_secret_word_3, req_secret_word_2,
                       req_secret_word_1, req_secret_word_0};
         id_in      = req_part_id;
         amount_in  = req_part_amount;
         total_in   = req_payment_total;
         now_in     = req_now_seconds;
         max_in     = req_max_ids;
         match_in   = 1'b0;
         free_in    = 1'b0;
         expire_in  = '0;
         exp_cnt_in = '0;
         n_in       = '0;
         status_in  = (kind_type'(req_kind) == KIND_ADD) ? STAT_REJECT : STAT_NOT_ADD;
      end

      // one entry per scan step: lowest match, lowest free, expiry
      if (cmd.scan_chk) begin
         if (key_hit && !match_ff) begin
            match_in     = 1'b1;
            match_idx_in = idx;
            hold_in      = rec_rd;
         end
         if (!active_ff[idx] && !free_ff) begin
            free_in     = 1'b1;
            free_idx_in = idx;
         end
         if (active_ff[idx] && (expiry_time <= now_ff)) begin
            expire_in[idx] = 1'b1;
            exp_cnt_in     = exp_cnt_ff + LW'(1);
         end
      end

      // new entry for an unknown key
      if (cmd.alloc) begin
         active_in[free_idx_ff] = 1'b1;
         live_in                = live_ff + LW'(1);
         hold_in                = {key_ff, total_ff, {WORD_W{1'b0}}, now_ff, {HW{1'b0}}};
      end

      if (cmd.remove) begin
         active_in[match_idx_ff] = 1'b0;
         live_in                 = live_ff - LW'(1);
      end

      // expired entries leave the table before their ids go out
      if (cmd.sweep_commit) begin
         active_in = active_ff & ~expire_ff;
         live_in   = live_ff - exp_cnt_ff;
      end

      if (cmd.hold_rec) begin
         hold_in = rec_rd;
      end

      if (cmd.add_sum) begin
         sum_in = {1'b0, hold_ff[SUM_LO +: WORD_W]} + {1'b0, amount_ff};
      end

      // record the part; the entry record is written back either way
      if (cmd.add_eval) begin
         rec_wr_en = 1'b1;
         if (part_ok) begin
            part_wr_en  = 1'b1;
            rec_wr_data = {hold_ff[KEY_LO +: KEY_W], hold_total, new_sum,
                           hold_ff[FIRST_LO +: TIME_W], held + HW'(1)};
            status_in   = (new_sum >= hold_total) ? STAT_COMPLETE : STAT_INCOMPLETE;
         end
      end

      if (cmd.emit_id) begin
         n_in = n_ff + COUNT_W'(1);
      end
   end

   // next values of the result register
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_status_in = out_status_ff;
      out_id_in     = out_id_ff;
      out_idv_in    = out_idv_ff;
      out_count_in  = out_count_ff;
      out_live_in   = out_live_ff;
      out_last_in   = out_last_ff;
      if (cmd.emit_id) begin
         out_valid_in  = 1'b1;
         out_status_in = STAT_NOT_ADD;
         out_id_in     = part_rd;
         out_idv_in    = 1'b1;
         out_count_in  = n_ff + COUNT_W'(1);
         out_live_in   = LIVE_OUT_W'(live_ff);
         out_last_in   = 1'b0;
      end else if (cmd.emit_close) begin
         out_valid_in  = 1'b1;
         out_status_in = status_ff;
         out_id_in     = '0;
         out_idv_in    = 1'b0;
         out_count_in  = n_ff;
         out_live_in   = LIVE_OUT_W'(live_ff);
         out_last_in   = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in  = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= '0;
         live_ff      <= '0;
         match_ff     <= 1'b0;
         free_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         live_ff      <= live_in;
         match_ff     <= match_in;
         free_ff      <= free_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      key_ff        <= key_in;
      id_ff         <= id_in;
      amount_ff     <= amount_in;
      total_ff      <= total_in;
      now_ff        <= now_in;
      max_ff        <= max_in;
      match_idx_ff  <= match_idx_in;
      free_idx_ff   <= free_idx_in;
      expire_ff     <= expire_in;
      exp_cnt_ff    <= exp_cnt_in;
      hold_ff       <= hold_in;
      sum_ff        <= sum_in;
      n_ff          <= n_in;
      status_ff     <= status_in;
      out_status_ff <= out_status_in;
      out_id_ff     <= out_id_in;
      out_idv_ff    <= out_idv_in;
      out_count_ff  <= out_count_in;
      out_live_ff   <= out_live_in;
      out_last_ff   <= out_last_in;
   end

   // entry records: key, total, collected sum, first seen, parts held
   ppat_ram #(
      .WIDTH (REC_W),
      .DEPTH (ENTRIES)
   ) u_rec_ram (
      .clock   (clock),
      .wr_en   (rec_wr_en),
      .wr_addr (sel_idx),
      .wr_data (rec_wr_data),
      .rd_addr (idx),
      .rd_data (rec_rd)
   );

   // part ids, one row of slots per entry
   ppat_ram #(
      .WIDTH (WORD_W),
      .DEPTH (PDEPTH)
   ) u_part_ram (
      .clock   (clock),
      .wr_en   (part_wr_en),
      .wr_addr (part_wr_addr),
      .wr_data (id_ff),
      .rd_addr (part_rd_addr),
      .rd_data (part_rd)
   );

   assign rsp_valid          = out_valid_ff;
   assign rsp_status         = out_status_ff;
   assign rsp_out_part_id    = out_id_ff;
   assign rsp_id_valid       = out_idv_ff;
   assign rsp_id_count       = out_count_ff;
   assign rsp_active_entries = out_live_ff;
   assign rsp_last           = out_last_ff;

   `PPAT_ASSERT(a_live_tracks_active, $countones(active_ff) == live_ff, "live count differs from active entries")
   `PPAT_ASSERT(a_emit_needs_room, (cmd.emit_id || cmd.emit_close) |-> out_free, "transfer loaded into a full result register")
   `PPAT_ASSERT(a_part_slot_in_range, part_wr_en |-> (held < HW'(PARTS_PER_ENTRY)), "part written beyond the entry slots")

endmodule

### src/payment_part_aggregation_table.sv
// top level of the payment part aggregation table
//
//   channel   direction  handshake                 payload
//   req_*     in         req_valid / req_stall     kind, secret words, part, total, time, max
//   rsp_*     out        rsp_valid / rsp_stall     status, part id, id valid, count, active, last
//   csr       in/out     psel penable pwrite       timeout_secs at byte address 0
//
// every item scans all entries through the record memory read port, and a sweep then
// makes a second pass that reads the records again
// reset (synchronous) empties the table and sets timeout_secs to 60
// a stalled result holds in the output register; a new item is taken once the closing
// result is loaded, and stalls on rsp only pause the id emit and closing steps
module payment_part_aggregation_table #(
   parameter int ENTRIES = 8,
   parameter int PARTS_PER_ENTRY = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [1:0]                           req_kind,
   input  logic [ppat_pkg::WORD_W-1:0]          req_secret_word_0,
   input  logic [ppat_pkg::WORD_W-1:0]          req_secret_word_1,
   input  logic [ppat_pkg::WORD_W-1:0]          req_secret_word_2,
   input  logic [ppat_pkg::WORD_W-1:0]          req_secret_word_3,
   input  logic [ppat_pkg::WORD_W-1:0]          req_part_id,
   input  logic [ppat_pkg::WORD_W-1:0]          req_part_amount,
   input  logic [ppat_pkg::WORD_W-1:0]          req_payment_total,
   input  logic [ppat_pkg::TIME_W-1:0]          req_now_seconds,
   input  logic [ppat_pkg::COUNT_W-1:0]         req_max_ids,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [1:0]                           rsp_status,
   output logic [ppat_pkg::WORD_W-1:0]          rsp_out_part_id,
   output logic                                 rsp_id_valid,
   output logic [ppat_pkg::COUNT_W-1:0]         rsp_id_count,
   output logic [ppat_pkg::LIVE_OUT_W-1:0]      rsp_active_entries,
   output logic                                 rsp_last,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [ppat_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [ppat_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [ppat_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                 pready
);
   import ppat_pkg::*;

   localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int HW = $clog2(PARTS_PER_ENTRY + 1);

   logic [TIME_W-1:0] timeout_ff, timeout_in;
   ctrl_cmd_type      cmd;
   dp_sts_type        sts;
   logic [EW-1:0]     idx;
   logic [HW-1:0]     part_idx;

   // configuration register
   always_comb begin
      timeout_in = timeout_ff;
      if (psel && penable && pwrite && (paddr[2] == REG_TIMEOUT)) begin
         timeout_in = pwdata[TIME_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
      end else begin
         timeout_ff <= timeout_in;
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_TIMEOUT) ? CSR_DATA_W'(timeout_ff) : '0;

   ppat_ctrl #(
      .ENTRIES         (ENTRIES),
      .PARTS_PER_ENTRY (PARTS_PER_ENTRY)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd),
      .idx       (idx),
      .part_idx  (part_idx)
   );

   ppat_dp #(
      .ENTRIES         (ENTRIES),
      .PARTS_PER_ENTRY (PARTS_PER_ENTRY)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .idx                (idx),
      .part_idx           (part_idx),
      .timeout_secs       (timeout_ff),
      .req_kind           (req_kind),
      .req_secret_word_0  (req_secret_word_0),
      .req_secret_word_1  (req_secret_word_1),
      .req_secret_word_2  (req_secret_word_2),
      .req_secret_word_3  (req_secret_word_3),
      .req_part_id        (req_part_id),
      .req_part_amount    (req_part_amount),
      .req_payment_total  (req_payment_total),
      .req_now_seconds    (req_now_seconds),
      .req_max_ids        (req_max_ids),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_out_part_id    (rsp_out_part_id),
      .rsp_id_valid       (rsp_id_valid),
      .rsp_id_count       (rsp_id_count),
      .rsp_active_entries (rsp_active_entries),
      .rsp_last           (rsp_last)
   );

endmodule

### sim/payment_part_aggregation_table_checker.sv
// result checker for the payment part aggregation table: predicts and compares
`timescale 1ns / 1ps
module payment_part_aggregation_table_checker
   import ppat_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic [1:0]             req_kind,
   input  logic [WORD_W-1:0]      req_secret_word_0,
   input  logic [WORD_W-1:0]      req_secret_word_1,
   input  logic [WORD_W-1:0]      req_secret_word_2,
   input  logic [WORD_W-1:0]      req_secret_word_3,
   input  logic [WORD_W-1:0]      req_part_id,
   input  logic [WORD_W-1:0]      req_part_amount,
   input  logic [WORD_W-1:0]      req_payment_total,
   input  logic [TIME_W-1:0]      req_now_seconds,
   input  logic [COUNT_W-1:0]     req_max_ids,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic [1:0]             rsp_status,
   input  logic [WORD_W-1:0]      rsp_out_part_id,
   input  logic                   rsp_id_valid,
   input  logic [COUNT_W-1:0]     rsp_id_count,
   input  logic [LIVE_OUT_W-1:0]  rsp_active_entries,
   input  logic                   rsp_last,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [CSR_ADDR_W-1:0]  paddr,
   input  logic [CSR_DATA_W-1:0]  pwdata,
   input  logic                   pready,
   output int                     errors,
   output int                     pending
);

   localparam int SLOTS = 8;
   localparam int PARTS = 8;

   typedef struct packed {
      logic [1:0]            status;
      logic [WORD_W-1:0]     id;
      logic                  id_valid;
      logic [COUNT_W-1:0]    count;
      logic [LIVE_OUT_W-1:0] live;
      logic                  last;
   } table_result_type;

   // shadow copy of the payment table
   logic              slot_used [SLOTS];
   logic [WORD_W-1:0] slot_key  [SLOTS][4];
   logic [WORD_W-1:0] slot_total[SLOTS];
   logic [WORD_W-1:0] slot_sum  [SLOTS];
   logic [TIME_W-1:0] slot_born [SLOTS];
   int                slot_parts[SLOTS];
   logic [WORD_W-1:0] slot_ids  [SLOTS][PARTS];
   int                live_slots;
   logic [TIME_W-1:0] expiry_secs;

   table_result_type awaited_results[$];

   assign pending = awaited_results.size();

   function automatic int find_slot(logic [WORD_W-1:0] k [4]);
      for (int i = 0; i < SLOTS; i++)
         if (slot_used[i] && slot_key[i][0] == k[0] && slot_key[i][1] == k[1] &&
             slot_key[i][2] == k[2] && slot_key[i][3] == k[3])
            return i;
      return -1;
   endfunction

   function automatic void drop_slot(int i);
      slot_used[i]  = 1'b0;
      slot_sum[i]   = '0;
      slot_parts[i] = 0;
      live_slots--;
   endfunction

   function automatic table_result_type make_result(status_type st, logic [WORD_W-1:0] id,
                                                    logic vld, int cnt, logic lst);
      table_result_type r;
      r.status   = st;
      r.id       = id;
      r.id_valid = vld;
      r.count    = COUNT_W'(cnt);
      r.live     = '0;
      r.last     = lst;
      return r;
   endfunction

   // add a part: find or allocate, then guard part count and overpayment
   function automatic status_type add_part(logic [WORD_W-1:0] k [4]);
      int e;
      logic [WORD_W:0] sum65;
      logic [WORD_W:0] dbl65;
      e = find_slot(k);
      if (e < 0) begin
         for (int i = 0; i < SLOTS; i++)
            if (!slot_used[i] && e < 0) e = i;
         if (e < 0) return STAT_REJECT;
         slot_key[e]   = k;
         slot_total[e] = req_payment_total;
         slot_sum[e]   = '0;
         slot_born[e]  = req_now_seconds;
         slot_parts[e] = 0;
         slot_used[e]  = 1'b1;
         live_slots++;
      end
      if (slot_parts[e] >= PARTS) return STAT_REJECT;
      sum65 = {1'b0, slot_sum[e]} + {1'b0, req_part_amount};
      dbl65 = {slot_total[e], 1'b0};
      if (sum65 > dbl65) return STAT_REJECT;
      slot_ids[e][slot_parts[e]] = req_part_id;
      slot_parts[e]++;
      slot_sum[e] = sum65[WORD_W] ? '1 : sum65[WORD_W-1:0];
      return (slot_sum[e] >= slot_total[e]) ? STAT_COMPLETE : STAT_INCOMPLETE;
   endfunction

   // work out every result one accepted transfer causes
   function automatic void predict_item();
      logic [WORD_W-1:0] k [4];
      table_result_type  batch[$];
      int                e;
      int                n;
      logic [TIME_W-1:0] due;
      k[0] = req_secret_word_0;
      k[1] = req_secret_word_1;
      k[2] = req_secret_word_2;
      k[3] = req_secret_word_3;
      n = 0;
      case (kind_type'(req_kind))
         KIND_ADD: begin
            batch.push_back(make_result(add_part(k), '0, 1'b0, 0, 1'b1));
         end
         KIND_SWEEP: begin
            for (int i = 0; i < SLOTS; i++) begin
               due = slot_born[i] + expiry_secs;
               if (slot_used[i] && due <= req_now_seconds) begin
                  for (int j = 0; j < slot_parts[i] && n < req_max_ids; j++) begin
                     n++;
                     batch.push_back(make_result(STAT_NOT_ADD, slot_ids[i][j], 1'b1, n, 1'b0));
                  end
                  drop_slot(i);
               end
            end
            batch.push_back(make_result(STAT_NOT_ADD, '0, 1'b0, n, 1'b1));
         end
         KIND_LIST: begin
            e = find_slot(k);
            if (e >= 0)
               for (int j = 0; j < slot_parts[e] && n < req_max_ids; j++) begin
                  n++;
                  batch.push_back(make_result(STAT_NOT_ADD, slot_ids[e][j], 1'b1, n, 1'b0));
               end
            batch.push_back(make_result(STAT_NOT_ADD, '0, 1'b0, n, 1'b1));
         end
         default: begin
            e = find_slot(k);
            if (e >= 0) drop_slot(e);
            batch.push_back(make_result(STAT_NOT_ADD, '0, 1'b0, 0, 1'b1));
         end
      endcase
      foreach (batch[i]) begin
         batch[i].live = LIVE_OUT_W'(live_slots);
         awaited_results.push_back(batch[i]);
      end
   endfunction

   // compare one result transfer with the oldest expectation
   function automatic void check_result();
      table_result_type want;
      table_result_type got;
      got.status   = rsp_status;
      got.id       = rsp_out_part_id;
      got.id_valid = rsp_id_valid;
      got.count    = rsp_id_count;
      got.live     = rsp_active_entries;
      got.last     = rsp_last;
      if (awaited_results.size() == 0) begin
         errors++;
         $display("%0t: unexpected result transfer, got %p", $realtime, got);
         return;
      end
      want = awaited_results.pop_front();
      if (want.status != got.status) begin
         errors++;
         $display("%0t: status expected %0d actual %0d", $realtime, want.status, got.status);
      end
      if (want.id != got.id) begin
         errors++;
         $display("%0t: part id expected %h actual %h", $realtime, want.id, got.id);
      end
      if (want.id_valid != got.id_valid) begin
         errors++;
         $display("%0t: id valid expected %0d actual %0d", $realtime, want.id_valid,
                  got.id_valid);
      end
      if (want.count != got.count) begin
         errors++;
         $display("%0t: id count expected %0d actual %0d", $realtime, want.count, got.count);
      end
      if (want.live != got.live) begin
         errors++;
         $display("%0t: active entries expected %0d actual %0d", $realtime, want.live,
                  got.live);
      end
      if (want.last != got.last) begin
         errors++;
         $display("%0t: last expected %0d actual %0d", $realtime, want.last, got.last);
      end
   endfunction

   initial errors = 0;

   // watch both channels and the register port
   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            slot_used[i]  = 1'b0;
            slot_sum[i]   = '0;
            slot_parts[i] = 0;
            slot_born[i]  = '0;
            slot_total[i] = '0;
         end
         live_slots  = 0;
         expiry_secs = TIMEOUT_RESET;
         awaited_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) check_result();
         if (req_valid && !req_stall) predict_item();
         if (psel && penable && pwrite && pready && paddr[CSR_ADDR_W-1:2] == REG_TIMEOUT)
            expiry_secs = pwdata;
      end
   end

endmodule

### sim/payment_part_aggregation_table_tb.sv
// stimulus and verdict for the payment part aggregation table
`timescale 1ns / 1ps
module payment_part_aggregation_table_tb;
   import ppat_pkg::*;

   localparam int KEYS = 12;
   localparam int RANDOM_PER_PHASE = 105;
   localparam int CYCLE_LIMIT = 1000000;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [1:0]            req_kind;
   logic [WORD_W-1:0]     req_secret_word_0;
   logic [WORD_W-1:0]     req_secret_word_1;
   logic [WORD_W-1:0]     req_secret_word_2;
   logic [WORD_W-1:0]     req_secret_word_3;
   logic [WORD_W-1:0]     req_part_id;
   logic [WORD_W-1:0]     req_part_amount;
   logic [WORD_W-1:0]     req_payment_total;
   logic [TIME_W-1:0]     req_now_seconds;
   logic [COUNT_W-1:0]    req_max_ids;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [1:0]            rsp_status;
   logic [WORD_W-1:0]     rsp_out_part_id;
   logic                  rsp_id_valid;
   logic [COUNT_W-1:0]    rsp_id_count;
   logic [LIVE_OUT_W-1:0] rsp_active_entries;
   logic                  rsp_last;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   int                    errors;
   int                    pending;
   int                    send_idle_pct;
   int                    recv_stall_pct;
   int                    cycles;
   int                    sent_items;
   logic [WORD_W-1:0]     key_pool[KEYS][4];
   logic [TIME_W-1:0]     clock_secs;

   payment_part_aggregation_table dut (.*);
   payment_part_aggregation_table_checker u_checker (.*);

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver stalls at random
   always @(posedge clock)
      rsp_stall <= (reset || recv_stall_pct == 0) ? 1'b0 : ($urandom_range(99) < recv_stall_pct);

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("payment_part_aggregation_table_tb: errors");
         $finish;
      end
   end

   function automatic logic [WORD_W-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // one input transfer, sometimes with a random gap before it
   task automatic send_item(kind_type kind, int key_idx, logic [WORD_W-1:0] id,
                            logic [WORD_W-1:0] amount, logic [WORD_W-1:0] total,
                            logic [TIME_W-1:0] now, logic [COUNT_W-1:0] max_ids);
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_kind          <= kind;
      req_secret_word_0 <= key_pool[key_idx][0];
      req_secret_word_1 <= key_pool[key_idx][1];
      req_secret_word_2 <= key_pool[key_idx][2];
      req_secret_word_3 <= key_pool[key_idx][3];
      req_part_id       <= id;
      req_part_amount   <= amount;
      req_payment_total <= total;
      req_now_seconds   <= now;
      req_max_ids       <= max_ids;
      @(negedge clock);
      while (req_stall) @(negedge clock);
      @(posedge clock);
      sent_items++;
   endtask

   // drain every result, then write the timeout register
   task automatic write_timeout(logic [CSR_DATA_W-1:0] value);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= CSR_ADDR_W'(REG_TIMEOUT) << 2;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_item();
      int                r;
      int                k;
      logic [WORD_W-1:0] total;
      logic [WORD_W-1:0] amount;
      r = $urandom_range(99);
      k = $urandom_range(KEYS - 1);
      if ($urandom_range(19) == 0) clock_secs = $urandom;
      else clock_secs = clock_secs + $urandom_range(0, 20);
      total  = WORD_W'($urandom_range(1000));
      amount = WORD_W'($urandom_range(400));
      if ($urandom_range(9) == 0) begin
         total  = '1;
         amount = ($urandom_range(1) != 0) ? '1 : rand64();
      end else if ($urandom_range(9) == 0) begin
         amount = rand64();
      end
      if (r < 55)
         send_item(KIND_ADD, k, rand64(), amount, total, clock_secs, COUNT_W'($urandom));
      else if (r < 70)
         send_item(KIND_LIST, k, rand64(), rand64(), rand64(), clock_secs,
                   COUNT_W'($urandom));
      else if (r < 80)
         send_item(KIND_REMOVE, k, rand64(), rand64(), rand64(), clock_secs,
                   COUNT_W'($urandom));
      else if (r < 92)
         send_item(KIND_SWEEP, k, rand64(), rand64(), rand64(), clock_secs,
                   COUNT_W'($urandom));
      else begin
         // unknown key and raw field values
         key_pool[KEYS-1] = '{rand64(), rand64(), rand64(), rand64()};
         send_item(kind_type'($urandom_range(3)), KEYS - 1, rand64(), rand64(), rand64(),
                   $urandom, COUNT_W'($urandom));
      end
   endtask

   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_kind          = KIND_ADD;
      req_secret_word_0 = '0;
      req_secret_word_1 = '0;
      req_secret_word_2 = '0;
      req_secret_word_3 = '0;
      req_part_id       = '0;
      req_part_amount   = '0;
      req_payment_total = '0;
      req_now_seconds   = '0;
      req_max_ids       = '0;
      rsp_stall         = 1'b0;
      psel              = 1'b0;
      penable           = 1'b0;
      pwrite            = 1'b0;
      paddr             = '0;
      pwdata            = '0;
      cycles            = 0;
      sent_items        = 0;
      send_idle_pct     = 11;
      recv_stall_pct    = 81;
      clock_secs        = '0;
      key_pool[0] = '{'0, '0, '0, '0};
      key_pool[1] = '{'1, '1, '1, '1};
      for (int i = 2; i < KEYS; i++)
         key_pool[i] = '{rand64(), rand64(), rand64(), rand64()};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // saturating sum on the all-ones key, then listing
      send_item(KIND_ADD, 1, '1, '1, '1, '0, '0);
      send_item(KIND_ADD, 1, 64'd7, 64'd5, '0, '0, '0);
      send_item(KIND_ADD, 1, 64'd8, '1, '0, '0, '0);
      send_item(KIND_LIST, 1, '0, '0, '0, '0, '1);
      send_item(KIND_LIST, 1, '0, '0, '0, '0, '0);
      send_item(KIND_LIST, 7, '0, '0, '0, '0, '1);
      // overpayment guard on the all-zero key
      send_item(KIND_ADD, 0, 64'd1, 64'd11, 64'd10, '0, '0);
      send_item(KIND_ADD, 0, 64'd2, 64'd10, 64'd10, '0, '0);
      // zero total, and a fresh entry whose first part is rejected
      send_item(KIND_ADD, 2, 64'd3, '0, '0, '0, '0);
      send_item(KIND_ADD, 3, 64'd4, 64'd1, '0, '0, '0);
      // part list overflow
      for (int i = 0; i < 9; i++) send_item(KIND_ADD, 4, rand64(), '0, '1, '0, '0);
      // fill the table; the last two keys find it full
      for (int i = 5; i < 9; i++) send_item(KIND_ADD, i, rand64(), 64'd1, 64'd9, '0, '0);
      send_item(KIND_ADD, 9, rand64(), 64'd1, 64'd9, '0, '0);
      send_item(KIND_REMOVE, 2, '0, '0, '0, '0, '0);
      send_item(KIND_REMOVE, 10, '0, '0, '0, '0, '0);
      // sweeps: nothing due, capped emit, zero max
      send_item(KIND_SWEEP, 0, '0, '0, '0, 32'd59, '1);
      send_item(KIND_SWEEP, 0, '0, '0, '0, 32'd60, 6'd3);
      send_item(KIND_SWEEP, 0, '0, '0, '0, '1, '0);

      // random phases, each under its own timeout and idling pattern
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: write_timeout('0);
            1: write_timeout('1);
            default: write_timeout($urandom_range(5, 200));
         endcase
         send_idle_pct  = (phase == 0) ? 11 : (phase == 1) ? 81 : 0;
         recv_stall_pct = (phase == 0) ? 81 : (phase == 1) ? 11 : 0;
         for (int i = 0; i < RANDOM_PER_PHASE; i++) random_item();
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("covered %0d items: add, sweep, list and remove under timeouts 60, 0,", sent_items);
      $display("all-ones and random, with sender gaps and receiver stalls on both sides");
      if (errors == 0)
         $display("payment_part_aggregation_table_tb: clean");
      else
         $display("payment_part_aggregation_table_tb: errors");
      $finish;
   end

endmodule

### files.f
+incdir+src
src/ppat_pkg.sv
src/ppat_ram.sv
src/ppat_ctrl.sv
src/ppat_dp.sv
src/payment_part_aggregation_table.sv
sim/payment_part_aggregation_table_checker.sv
sim/payment_part_aggregation_table_tb.sv
